// ===== sv/adc_settle_and_window_select_defines.svh =====
// Assertion macros shared by the settle-and-window selector RTL.
`ifndef ADC_SETTLE_AND_WINDOW_SELECT_DEFINES_SVH
`define ADC_SETTLE_AND_WINDOW_SELECT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define ASWS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asws assertion failed");
// Next-cycle implication, disabled during reset
`define ASWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asws assertion failed");
`else
`define ASWS_ASSERT_IMP(label, clk, rst, ante, cons)
`define ASWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/asws_pkg.sv =====
// Types, constants and register codes of the settle-and-window selector.
package asws_pkg;

   // Field widths
   localparam int RAW_W      = 16;
   localparam int VAL_W      = 12;
   localparam int TOL_W      = 12;
   localparam int READS_W    = 3;
   localparam int NRANGE_W   = 3;
   localparam int RANGE_W    = 24;
   localparam int RUN_W      = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Elaboration defaults
   localparam int MAX_RANGES_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int NUM_RANGE_REGS  = 4;

   // Behavior constants
   localparam logic signed [VAL_W-1:0] EDGE_LIMIT    = 12'sd2047;
   localparam logic [RUN_W-1:0]        STABLE_NEEDED = 2'd3;
   localparam logic [READS_W-1:0]      READ_CAP      = 3'd6;
   localparam logic [TOL_W-1:0]        TOL_RESET     = 12'd10;

   // Input action codes
   typedef enum logic {
      ACT_BEGIN  = 1'b0,
      ACT_FOLLOW = 1'b1
   } action_type;

   // Register indexes (byte address is 4 times the index)
   typedef enum logic [2:0] {
      REG_TOLERANCE  = 3'd0,
      REG_MAX_READS  = 3'd1,
      REG_NUM_RANGES = 3'd2,
      REG_RANGE_A    = 3'd3,
      REG_RANGE_B    = 3'd4,
      REG_RANGE_C    = 3'd5,
      REG_RANGE_D    = 3'd6
   } reg_idx_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_WALK = 2'd1,
      BK_DONE = 2'd2
   } back_state_type;

   // Settings seen by the front end
   typedef struct packed {
      logic [TOL_W-1:0]   tolerance;
      logic [READS_W-1:0] max_reads;
   } front_cfg_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== sv/asws_req_if.sv =====
// Input channel: raw converter words with a begin/follow-on action.
interface asws_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] raw_sample;

   modport source (output valid, output action, output raw_sample, input ready);
   modport sink (input valid, input action, input raw_sample, output ready);
endinterface

// ===== sv/asws_rsp_if.sv =====
// Result channel: final reading, window threshold words and in-range flag.
interface asws_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] value;
   logic [15:0]        low_word;
   logic [15:0]        high_word;
   logic               in_range;

   modport source (output valid, output value, output low_word, output high_word,
                   output in_range, input ready);
   modport sink (input valid, input value, input low_word, input high_word,
                 input in_range, output ready);
endinterface

// ===== sv/asws_queue.sv =====
// Short flop-based queue carrying finished readings from front to back.
module asws_queue
   import asws_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF,
   parameter int WIDTH = VAL_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output q_stat_type       stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // Gate the strobes with the fill state
   assign do_push    = push && (count_ff != FULL_CNT);
   assign do_pop     = pop && (count_ff != '0);
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/asws_front.sv =====
// Front end: scales each word, tracks settling and queues final readings.
module asws_front
   import asws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   asws_req_if.sink          req_ch,
   input  front_cfg_type     cfg,
   input  q_stat_type        q_stat,
   output logic              push,
   output logic [VAL_W-1:0]  push_data
);

   logic                      busy_ff, busy_in;
   logic signed [VAL_W-1:0]   prev_ff, prev_in;
   logic [RUN_W-1:0]          run_ff, run_in;
   logic [READS_W-1:0]        left_ff, left_in;

   logic                      accept;
   logic [RAW_W-1:0]          bias;
   logic [RAW_W-1:0]          biased;
   logic signed [VAL_W-1:0]   cur;
   logic signed [VAL_W:0]     diff;
   logic [VAL_W:0]            mag;
   logic                      stable;
   logic [RUN_W-1:0]          run_next;
   logic [READS_W-1:0]        left_dec;
   logic [READS_W-1:0]        budget;

   assign req_ch.ready = !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Divide by 16 toward zero: add 15 to negative words, then drop four bits
   assign bias   = {{(RAW_W-4){1'b0}}, {4{req_ch.raw_sample[RAW_W-1]}}};
   assign biased = req_ch.raw_sample + bias;
   assign cur    = $signed(biased[RAW_W-1:4]);

   // Tolerance window around the previous reading
   assign diff   = {cur[VAL_W-1], cur} - {prev_ff[VAL_W-1], prev_ff};
   assign mag    = diff[VAL_W] ? (VAL_W+1)'(0) - diff : diff;
   assign stable = (mag <= {1'b0, cfg.tolerance});

   // Clamp the read budget to one through six
   always_comb begin
      if (cfg.max_reads == '0) begin
         budget = READS_W'(1);
      end else if (cfg.max_reads > READ_CAP) begin
         budget = READ_CAP;
      end else begin
         budget = cfg.max_reads;
      end
   end

   assign run_next  = stable ? run_ff + 1'b1 : '0;
   assign left_dec  = (left_ff != '0) ? left_ff - 1'b1 : '0;
   assign push_data = cur;

   // Measurement bookkeeping
   always_comb begin
      busy_in = busy_ff;
      prev_in = prev_ff;
      run_in  = run_ff;
      left_in = left_ff;
      push    = 1'b0;
      if (accept) begin
         if (req_ch.action == ACT_BEGIN) begin
            busy_in = 1'b1;
            prev_in = cur;
            run_in  = '0;
            left_in = budget;
         end else if (busy_ff) begin
            if (run_next == STABLE_NEEDED) begin
               push    = 1'b1;
               busy_in = 1'b0;
               run_in  = '0;
               left_in = '0;
            end else begin
               prev_in = cur;
               if (left_dec == '0) begin
                  push    = 1'b1;
                  busy_in = 1'b0;
                  run_in  = '0;
                  left_in = '0;
               end else begin
                  run_in  = run_next;
                  left_in = left_dec;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prev_ff <= '0;
         run_ff  <= '0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         prev_ff <= prev_in;
         run_ff  <= run_in;
         left_ff <= left_in;
      end
   end

endmodule

// ===== sv/asws_back.sv =====
// Back end: walks the range entries with one comparator and holds the result.
module asws_back
   import asws_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  q_stat_type          q_stat,
   input  logic [VAL_W-1:0]    pop_data,
   output logic                pop,
   input  logic [NRANGE_W-1:0] num_ranges,
   input  logic [RANGE_W-1:0]  range_cfg [MAX_RANGES],
   asws_rsp_if.source          rsp_ch
);

   localparam int CNT_W  = $clog2(MAX_RANGES + 1);
   localparam int RIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   back_state_type          state_ff, state_in;
   logic signed [VAL_W-1:0] v_ff, v_in;
   logic signed [VAL_W-1:0] lo_ff, lo_in;
   logic signed [VAL_W-1:0] hi_ff, hi_in;
   logic                    hit_ff, hit_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   logic [CNT_W-1:0]        limit;
   logic [RANGE_W-1:0]      entry;
   logic signed [VAL_W-1:0] rl, ru;
   logic                    hit_now;
   logic                    walk_end;

   // Entries walked: num_ranges capped at the parameter
   assign limit = (num_ranges > NRANGE_W'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
                                                       : CNT_W'(num_ranges);

   // One entry per cycle through a single compare pair
   assign entry    = range_cfg[cnt_ff[RIDX_W-1:0]];
   assign rl       = $signed(entry[VAL_W-1:0]);
   assign ru       = $signed(entry[RANGE_W-1:VAL_W]);
   assign hit_now  = (rl <= v_ff) && (ru >= v_ff);
   assign walk_end = (cnt_ff == limit);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) state_in = BK_WALK;
         end
         BK_WALK: begin
            if (walk_end || hit_now) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (rsp_ch.ready) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      pop              = (state_ff == BK_IDLE) && !q_stat.empty;
      rsp_ch.valid     = (state_ff == BK_DONE);
      rsp_ch.value     = v_ff;
      rsp_ch.low_word  = {lo_ff, 4'b0000};
      rsp_ch.high_word = {hi_ff, 4'b0000};
      rsp_ch.in_range  = hit_ff;
   end

   // Load a reading, then narrow the window entry by entry
   always_comb begin
      v_in   = v_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      hit_in = hit_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               v_in   = $signed(pop_data);
               lo_in  = -EDGE_LIMIT;
               hi_in  = EDGE_LIMIT;
               hit_in = 1'b0;
               cnt_in = '0;
            end
         end
         BK_WALK: begin
            if (!walk_end) begin
               if (hit_now) begin
                  lo_in  = rl;
                  hi_in  = ru;
                  hit_in = 1'b1;
               end else begin
                  if ((ru < v_ff) && (lo_ff < ru)) lo_in = ru;
                  if ((rl > v_ff) && (hi_ff > rl)) hi_in = rl;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         BK_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         hit_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      v_ff  <= v_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

endmodule

// ===== sv/adc_settle_and_window_select.sv =====
// Top level of the settle-and-window selector: registers, front, queue, back.
//
//   channel   direction   handshake            payload
//   req_ch    in          valid/ready          action, raw_sample
//   rsp_ch    out         valid/ready          value, low_word, high_word, in_range
//   csr_*     in          APB write, pready=1  seven registers at 4*index
//
// The front end takes one transaction per cycle while the queue has room.
// The back end pops a reading, walks the entries (limit = walked entries, at most
// MAX_RANGES) plus a final check, then shows the result until rsp_ch takes it;
// an entry that holds the reading ends the walk early.
// A finished result waiting on rsp_ch stalls only the back end; the queue of
// QUEUE_DEPTH readings keeps the front end accepting until it fills.
// Reset is synchronous; it clears control state and settings, not queue or payload data.
`include "adc_settle_and_window_select_defines.svh"

module adc_settle_and_window_select
   import asws_pkg::*;
#(
   parameter int MAX_RANGES  = MAX_RANGES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   asws_req_if.sink              req_ch,
   asws_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TOL_W-1:0]    tol_ff;
   logic [READS_W-1:0]  max_reads_ff;
   logic [NRANGE_W-1:0] num_ranges_ff;
   logic [RANGE_W-1:0]  range_a_ff, range_b_ff, range_c_ff, range_d_ff;

   logic [RANGE_W-1:0]  range_all  [NUM_RANGE_REGS];
   logic [RANGE_W-1:0]  range_walk [MAX_RANGES];

   reg_idx_type         reg_idx;
   logic                csr_wr;
   front_cfg_type       front_cfg;
   q_stat_type          q_stat;
   logic                push, pop;
   logic [VAL_W-1:0]    push_data, pop_data;

   logic signed [RAW_W-1:0] value_word;
   logic                    window_holds;

   // Register port decode
   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff        <= TOL_RESET;
         max_reads_ff  <= '0;
         num_ranges_ff <= '0;
         range_a_ff    <= '0;
         range_b_ff    <= '0;
         range_c_ff    <= '0;
         range_d_ff    <= '0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_TOLERANCE:  tol_ff        <= csr_pwdata[TOL_W-1:0];
            REG_MAX_READS:  max_reads_ff  <= csr_pwdata[READS_W-1:0];
            REG_NUM_RANGES: num_ranges_ff <= csr_pwdata[NRANGE_W-1:0];
            REG_RANGE_A:    range_a_ff    <= csr_pwdata[RANGE_W-1:0];
            REG_RANGE_B:    range_b_ff    <= csr_pwdata[RANGE_W-1:0];
            REG_RANGE_C:    range_c_ff    <= csr_pwdata[RANGE_W-1:0];
            REG_RANGE_D:    range_d_ff    <= csr_pwdata[RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_TOLERANCE:  csr_prdata = CSR_DATA_W'(tol_ff);
         REG_MAX_READS:  csr_prdata = CSR_DATA_W'(max_reads_ff);
         REG_NUM_RANGES: csr_prdata = CSR_DATA_W'(num_ranges_ff);
         REG_RANGE_A:    csr_prdata = CSR_DATA_W'(range_a_ff);
         REG_RANGE_B:    csr_prdata = CSR_DATA_W'(range_b_ff);
         REG_RANGE_C:    csr_prdata = CSR_DATA_W'(range_c_ff);
         REG_RANGE_D:    csr_prdata = CSR_DATA_W'(range_d_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Hand the walked entries to the back end
   assign range_all[0] = range_a_ff;
   assign range_all[1] = range_b_ff;
   assign range_all[2] = range_c_ff;
   assign range_all[3] = range_d_ff;

   for (genvar gi = 0; gi < MAX_RANGES; gi++) begin : g_walk
      assign range_walk[gi] = range_all[gi];
   end

   assign front_cfg.tolerance = tol_ff;
   assign front_cfg.max_reads = max_reads_ff;

   asws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (front_cfg),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   asws_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (VAL_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   asws_back #(
      .MAX_RANGES (MAX_RANGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .num_ranges (num_ranges_ff),
      .range_cfg  (range_walk),
      .rsp_ch     (rsp_ch)
   );

   // Reading scaled back to a threshold word, and whether the window covers it
   assign value_word   = {rsp_ch.value, 4'b0000};
   assign window_holds = ($signed(rsp_ch.low_word) <= value_word) &&
                         ($signed(rsp_ch.high_word) >= value_word);

   // Checks
   `ASWS_ASSERT_IMP(a_no_push_full, clock, reset, push, !q_stat.full)
   `ASWS_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, !q_stat.empty)
   `ASWS_ASSERT_NEXT(a_rsp_once, clock, reset, (rsp_ch.valid && rsp_ch.ready), !rsp_ch.valid)
   `ASWS_ASSERT_IMP(a_hit_inside, clock, reset, (rsp_ch.valid && rsp_ch.in_range), window_holds)

endmodule

// ===== dv/adc_settle_and_window_select_tb.sv =====
// Self-checking testbench for the ADC settle-and-window selector.
`timescale 1ns / 1ps

import asws_pkg::*;

// Settle and window predictor with the queue of results still owed by the block
class window_scoreboard;

   typedef struct {
      logic [11:0] value;
      logic [15:0] low_word;
      logic [15:0] high_word;
      logic        in_range;
   } window_result_type;

   // register copies
   int unsigned tol_reg;
   int unsigned reads_reg;
   int unsigned ranges_used;
   logic [23:0] range_reg[4];

   // measurement state
   bit          busy;
   int          prev_reading;
   int unsigned run_count;
   int unsigned reads_left;

   window_result_type owed_q[$];
   int errors;

   function new();
      tol_reg = 10;
      reads_reg = 0;
      ranges_used = 0;
      foreach (range_reg[i]) range_reg[i] = '0;
      busy = 1'b0;
      prev_reading = 0;
      run_count = 0;
      reads_left = 0;
      errors = 0;
   endfunction

   function void set_reg(reg_idx_type idx, logic [31:0] data);
      case (idx)
         REG_TOLERANCE:  tol_reg = data[11:0];
         REG_MAX_READS:  reads_reg = data[2:0];
         REG_NUM_RANGES: ranges_used = data[2:0];
         REG_RANGE_A:    range_reg[0] = data[23:0];
         REG_RANGE_B:    range_reg[1] = data[23:0];
         REG_RANGE_C:    range_reg[2] = data[23:0];
         REG_RANGE_D:    range_reg[3] = data[23:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return owed_q.size();
   endfunction

   // Walk the ranges for the final reading and queue the window it selects
   function void settle(int reading);
      window_result_type res;
      int lo_edge;
      int hi_edge;
      int rl;
      int ru;
      int walk;
      bit hit;
      lo_edge = -2047;
      hi_edge = 2047;
      hit = 1'b0;
      walk = (ranges_used > 4) ? 4 : ranges_used;
      for (int i = 0; i < walk; i++) begin
         rl = $signed(range_reg[i][11:0]);
         ru = $signed(range_reg[i][23:12]);
         if (rl <= reading && ru >= reading) begin
            lo_edge = rl;
            hi_edge = ru;
            hit = 1'b1;
            break;
         end
         if (ru < reading && lo_edge < ru) lo_edge = ru;
         if (rl > reading && hi_edge > rl) hi_edge = rl;
      end
      res.value = 12'(reading);
      res.low_word = 16'(lo_edge * 16);
      res.high_word = 16'(hi_edge * 16);
      res.in_range = hit;
      owed_q.push_back(res);
      busy = 1'b0;
      run_count = 0;
      reads_left = 0;
   endfunction

   // Advance the measurement by one accepted transaction
   function void note_input(action_type act, logic [15:0] raw);
      int reading;
      int tol;
      int unsigned budget;
      reading = $signed(raw);
      reading = reading / 16;
      tol = tol_reg;
      if (act == ACT_BEGIN) begin
         budget = reads_reg;
         if (budget < 1) budget = 1;
         if (budget > 6) budget = 6;
         busy = 1'b1;
         prev_reading = reading;
         run_count = 0;
         reads_left = budget;
         return;
      end
      if (!busy) return;
      if (reading >= prev_reading - tol && reading <= prev_reading + tol)
         run_count++;
      else
         run_count = 0;
      if (run_count >= 3) begin
         settle(reading);
         return;
      end
      prev_reading = reading;
      if (reads_left > 0) reads_left--;
      if (reads_left == 0) settle(reading);
   endfunction

   // Compare one accepted result against the oldest owed window
   function void check(logic [11:0] value, logic [15:0] low_word, logic [15:0] high_word,
                       logic in_range);
      window_result_type exp_res;
      if (owed_q.size() == 0) begin
         errors++;
         if (errors < 60)
            $display("%0t: result with none owed: value %0d low %h high %h flag %b",
                     $time, $signed(value), low_word, high_word, in_range);
         return;
      end
      exp_res = owed_q.pop_front();
      if (value !== exp_res.value) begin
         errors++;
         if (errors < 60)
            $display("%0t: value mismatch: expected %0d, got %0d", $time,
                     $signed(exp_res.value), $signed(value));
      end
      if (low_word !== exp_res.low_word) begin
         errors++;
         if (errors < 60)
            $display("%0t: low_word mismatch: expected %h, got %h", $time,
                     exp_res.low_word, low_word);
      end
      if (high_word !== exp_res.high_word) begin
         errors++;
         if (errors < 60)
            $display("%0t: high_word mismatch: expected %h, got %h", $time,
                     exp_res.high_word, high_word);
      end
      if (in_range !== exp_res.in_range) begin
         errors++;
         if (errors < 60)
            $display("%0t: in_range mismatch: expected %b, got %b", $time,
                     exp_res.in_range, in_range);
      end
   endfunction
endclass

module adc_settle_and_window_select_tb
   import asws_pkg::*;
();

   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_GROUPS = 20;
   localparam int GROUP_ITEMS   = 50;
   localparam int HOLD_CYCLES   = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   asws_req_if req_ch ();
   asws_rsp_if rsp_ch ();

   window_scoreboard sb;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asks = 0;
   int cur_tol = 10;

   adc_settle_and_window_select i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Drive ready: honor a long hold-off first, else stall at the phase rate
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Check each result transaction as it is accepted
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check(rsp_ch.value, rsp_ch.low_word, rsp_ch.high_word, rsp_ch.in_range);
   end

   // Offer one transaction after a random idle gap, hold it until accepted
   task automatic send_item(action_type act, logic [15:0] raw);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.raw_sample <= raw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_input(act, raw);
   endtask

   // Drop valid, wait for every owed result, then let the back end go quiet
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task automatic csr_write(reg_idx_type idx, logic [31:0] data);
      logic [31:0] mask;
      case (idx)
         REG_TOLERANCE:                 mask = 32'h0000_0FFF;
         REG_MAX_READS, REG_NUM_RANGES: mask = 32'h0000_0007;
         default:                       mask = 32'h00FF_FFFF;
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= data & mask;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== (data & mask)) begin
         sb.errors++;
         $display("%0t: register %s read-back mismatch: expected %h, got %h", $time,
                  idx.name(), data & mask, csr_prdata);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_reg(idx, data & mask);
      if (idx == REG_TOLERANCE) cur_tol = data[11:0];
   endtask

   function automatic logic [23:0] pack_range(int lo_edge, int hi_edge);
      return {12'(hi_edge), 12'(lo_edge)};
   endfunction

   // Mostly ordered ranges, some inverted, some raw bit patterns
   function automatic logic [23:0] rand_range();
      int sel;
      int lo_edge;
      int hi_edge;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 24'($urandom());
      lo_edge = int'($urandom_range(0, 4095)) - 2048;
      hi_edge = lo_edge + int'($urandom_range(0, 1500));
      if (hi_edge > 2047) hi_edge = 2047;
      if (sel == 1) return pack_range(hi_edge + 1 > 2047 ? 2047 : hi_edge + 1, lo_edge);
      return pack_range(lo_edge, hi_edge);
   endfunction

   // Follow-on word close to the last one, scaled to the tolerance in use
   function automatic logic [15:0] near_raw(logic [15:0] base);
      int span;
      int delta;
      span = ((cur_tol < 100) ? cur_tol + 2 : 100) * 16;
      delta = int'($urandom_range(0, 2 * span)) - span;
      return 16'(int'(base) + delta);
   endfunction

   task automatic random_config(int group);
      int tol_sel;
      logic [11:0] tol;
      tol_sel = $urandom_range(0, 5);
      case (tol_sel)
         0:       tol = 12'd0;
         1:       tol = 12'd4095;
         2:       tol = 12'($urandom());
         default: tol = 12'($urandom_range(0, 30));
      endcase
      if (group == 0) tol = 12'd4095;
      csr_write(REG_TOLERANCE, 32'(tol));
      csr_write(REG_MAX_READS, 32'($urandom_range(0, 7)));
      csr_write(REG_NUM_RANGES, 32'($urandom_range(0, 7)));
      for (int i = 0; i < 4; i++)
         csr_write(reg_idx_type'(REG_RANGE_A + i), (group == 1) ? 32'd0 : 32'(rand_range()));
   endtask

   initial begin
      int items;
      int follows;
      logic [15:0] raw;

      req_ch.valid = 1'b0;
      req_ch.action = ACT_BEGIN;
      req_ch.raw_sample = '0;
      sb = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: single follow-on budget, two ordered ranges
      csr_write(REG_TOLERANCE, 32'd10);
      csr_write(REG_MAX_READS, 32'd0);
      csr_write(REG_NUM_RANGES, 32'd2);
      csr_write(REG_RANGE_A, 32'(pack_range(-100, 100)));
      csr_write(REG_RANGE_B, 32'(pack_range(500, 1000)));
      csr_write(REG_RANGE_C, 32'd0);
      csr_write(REG_RANGE_D, 32'd0);
      send_item(ACT_FOLLOW, 16'h1234);   // ignored while idle
      send_item(ACT_BEGIN, 16'h7FFF);    // full scale positive
      send_item(ACT_FOLLOW, 16'h8000);   // full scale negative, budget spent
      send_item(ACT_BEGIN, 16'h0000);
      send_item(ACT_FOLLOW, 16'hFFFF);   // truncates toward zero
      send_item(ACT_BEGIN, 16'hFFF1);
      send_item(ACT_BEGIN, 16'h3E80);    // restart while busy
      send_item(ACT_FOLLOW, 16'h3E8F);
      send_item(ACT_FOLLOW, 16'hFFFF);   // ignored while idle
      wait_drained();

      // Directed: zero tolerance, clamped budget, too many ranges, inverted range
      csr_write(REG_TOLERANCE, 32'd0);
      csr_write(REG_MAX_READS, 32'd7);
      csr_write(REG_NUM_RANGES, 32'd7);
      csr_write(REG_RANGE_A, 32'(pack_range(300, -300)));
      csr_write(REG_RANGE_B, 32'(pack_range(10, 20)));
      csr_write(REG_RANGE_C, 32'(pack_range(-50, -40)));
      csr_write(REG_RANGE_D, 32'hFF_FFFF);
      send_item(ACT_BEGIN, 16'h0050);
      repeat (3) send_item(ACT_FOLLOW, 16'h0050);   // three stable readings
      send_item(ACT_BEGIN, 16'h0000);
      for (int i = 1; i <= 6; i++) send_item(ACT_FOLLOW, 16'(i * 16)); // budget runs out
      wait_drained();

      // Back-pressure: hold the receiver off while pairs keep coming
      csr_write(REG_MAX_READS, 32'd0);
      hold_asks++;
      for (int i = 0; i < 16; i++) begin
         send_item(ACT_BEGIN, 16'($urandom()));
         send_item(ACT_FOLLOW, 16'($urandom()));
      end
      wait_drained();

      // Random groups, each with fresh settings and an idling phase
      for (int g = 0; g < RANDOM_GROUPS; g++) begin
         random_config(g);
         case (g % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         items = 0;
         while (items < GROUP_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               raw = 16'($urandom());
               send_item(ACT_BEGIN, raw);
               items++;
               follows = $urandom_range(1, 7);
               for (int k = 0; k < follows; k++) begin
                  if ($urandom_range(0, 99) < 75) raw = near_raw(raw);
                  else raw = 16'($urandom());
                  send_item(ACT_FOLLOW, raw);
                  items++;
               end
            end else begin
               send_item(action_type'($urandom_range(0, 1)), 16'($urandom()));
               items++;
            end
         end
         wait_drained();
      end

      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/asws_pkg.sv
sv/asws_req_if.sv
sv/asws_rsp_if.sv
sv/asws_queue.sv
sv/asws_front.sv
sv/asws_back.sv
sv/adc_settle_and_window_select.sv
dv/adc_settle_and_window_select_tb.sv
